// ===== rtl/core/code_prefix_to_text_lookup_top_assert.svh =====
// Assertion macros for the prefix dictionary lookup checker.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef CODE_PREFIX_TO_TEXT_LOOKUP_TOP_ASSERT_SVH
`define CODE_PREFIX_TO_TEXT_LOOKUP_TOP_ASSERT_SVH

// Property that must hold at every sampled edge.
`define CPTL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent on one edge implies consequent on the next.
`define CPTL_ASSERT_NEXT(label, ante, cons, msg) \
	`CPTL_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ===== rtl/core/cptl_pkg.sv =====
package cptl_pkg;

	// Results of one lookup never exceed this many text bytes.
	localparam int RESULT_LIMIT = 32;
	// Bytes held by the window and by a stored code word.
	localparam int CODE_WORD_BYTES = 4;

	typedef enum logic [1:0] {
		CMD_CODE   = 2'd0,
		CMD_TEXT   = 2'd1,
		CMD_LOOKUP = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_UNIQUE = 2'd0,
		ST_NONE   = 2'd1,
		ST_AMBIG  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_TXT_RD,
		S_TXT_OUT,
		S_STATUS
	} state_t;

	typedef struct packed {
		logic [31:0] code;
		logic [2:0]  code_length;
		logic [5:0]  text_length;
	} entry_t;

	typedef struct packed {
		logic        code_we;
		logic        text_we;
		logic [7:0]  entry_index;
		logic [31:0] code_bytes;
		logic [2:0]  code_length;
		logic [5:0]  text_length;
		logic [4:0]  text_position;
		logic [7:0]  text_value;
	} store_wr_t;

	// Byte k of a code word; bytes past the word read as zero.
	function automatic logic [7:0] byte_at(input logic [31:0] word, input logic [3:0] k);
		logic [7:0] b;
		b = 8'd0;
		if (k < 4'(CODE_WORD_BYTES)) begin
			b = word[{k[1:0], 3'b000} +: 8];
		end
		return b;
	endfunction

endpackage

// ===== rtl/core/cptl_if.sv =====
interface cptl_in_if;
	import cptl_pkg::*;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [7:0]  entry_index;
	logic [31:0] code_bytes;
	logic [2:0]  code_length;
	logic [5:0]  text_length;
	logic [4:0]  text_position;
	logic [7:0]  text_value;

	modport source (
		output valid, command, entry_index, code_bytes, code_length,
		       text_length, text_position, text_value,
		input  ready
	);
	modport sink (
		input  valid, command, entry_index, code_bytes, code_length,
		       text_length, text_position, text_value,
		output ready
	);
endinterface

interface cptl_out_if;
	import cptl_pkg::*;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [2:0] consumed_length;
	logic [7:0] text_byte;
	logic [5:0] text_total;
	logic       last;

	modport source (
		output valid, status, consumed_length, text_byte, text_total, last,
		input  ready
	);
	modport sink (
		input  valid, status, consumed_length, text_byte, text_total, last,
		output ready
	);
endinterface

// ===== rtl/core/cptl_store.sv =====
module cptl_store
	import cptl_pkg::*;
#(
	parameter int MAX_ENTRIES    = 256,
	parameter int MAX_CODE_BYTES = 4,
	parameter int MAX_TEXT_BYTES = 32,
	localparam int EW = $clog2(MAX_ENTRIES),
	localparam int TW = (MAX_TEXT_BYTES > 1) ? $clog2(MAX_TEXT_BYTES) : 1
) (
	input  logic            clk,
	input  store_wr_t       wr,
	input  logic [EW-1:0]   entry_raddr,
	output entry_t          entry_rdata,
	input  logic [EW+TW-1:0] text_raddr,
	output logic [7:0]      text_rdata
);

	localparam int TLIM = (MAX_TEXT_BYTES < RESULT_LIMIT) ? MAX_TEXT_BYTES : RESULT_LIMIT;
	localparam int TDEPTH = MAX_ENTRIES * (2 ** TW);

	entry_t     entry_mem [MAX_ENTRIES];
	logic [7:0] text_mem [TDEPTH];

	logic       idx_ok;
	logic       pos_ok;
	entry_t     entry_wdata;

	assign idx_ok = 32'(wr.entry_index) < MAX_ENTRIES;
	assign pos_ok = 32'(wr.text_position) < MAX_TEXT_BYTES;

	// Clamp lengths to what the store and the result stream can hold.
	always_comb begin
		entry_wdata.code = wr.code_bytes;
		entry_wdata.code_length = wr.code_length;
		if (32'(wr.code_length) > MAX_CODE_BYTES) begin
			entry_wdata.code_length = 3'(MAX_CODE_BYTES);
		end
		entry_wdata.text_length = wr.text_length;
		if (32'(wr.text_length) > TLIM) begin
			entry_wdata.text_length = 6'(TLIM);
		end
	end

	always_ff @(posedge clk) begin
		if (wr.code_we && idx_ok) begin
			entry_mem[EW'(wr.entry_index)] <= entry_wdata;
		end
		entry_rdata <= entry_mem[entry_raddr];
	end

	always_ff @(posedge clk) begin
		if (wr.text_we && idx_ok && pos_ok) begin
			text_mem[{EW'(wr.entry_index), TW'(wr.text_position)}] <= wr.text_value;
		end
		text_rdata <= text_mem[text_raddr];
	end

endmodule

// ===== rtl/core/code_prefix_to_text_lookup_top.sv =====
// Prefix-code dictionary lookup. Write items (command 0, 1) load an entry's code
// word with its lengths, or one text byte, and give no result. A lookup (command 2)
// filters the first entry_count entries against the window one code byte per pass
// through a single byte-compare unit: the first pass reads every searched entry and
// also finds the longest code, later passes walk only the survivors kept in a
// candidate memory. A pass issues one read per candidate and lets the reads drain
// through the scan pipeline (s1, s2) until it is empty; a decision state then ends
// the lookup or starts the next pass. A unique match streams its text, each byte a
// text memory read followed by a transfer that waits while the output register is
// full. The input side is ready only between lookups; the last result may still
// wait in the output register while the next item is taken. Stores are not cleared
// at reset: an entry must be written before a lookup can reach it.
module code_prefix_to_text_lookup_top
	import cptl_pkg::*;
#(
	parameter int MAX_ENTRIES    = 256,
	parameter int MAX_CODE_BYTES = 4,
	parameter int MAX_TEXT_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	cptl_in_if.sink     in,
	cptl_out_if.source  out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int EW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int TW = (MAX_TEXT_BYTES > 1) ? $clog2(MAX_TEXT_BYTES) : 1;
	localparam int BW = (MAX_CODE_BYTES > 1) ? $clog2(MAX_CODE_BYTES) : 1;

	state_t      state_q, state_d;
	logic [8:0]  entry_count_q;
	logic [CW-1:0] n_eff;

	// Lookup working registers
	logic [31:0]   win_q;
	logic [BW-1:0] bidx_q;
	logic [2:0]    longest_q;
	logic [CW-1:0] rd_q, old_q, mcnt_q;
	status_t       pend_status_q;

	// Scan pipeline: s1 holds the candidate index, s2 the entry read back.
	logic          v_s1, v_s2;
	logic [EW-1:0] idx_s1, e_s1, e_s2;
	logic [EW-1:0] cand_rd_q;
	logic [EW-1:0] cand_mem [MAX_ENTRIES];

	// Last hit seen in the current pass
	logic [EW-1:0] hit_e_q;
	logic [2:0]    hit_clen_q;
	logic [5:0]    hit_tlen_q;
	logic [5:0]    k_q;

	// Output register
	logic          out_valid_q;
	logic [1:0]    out_status_q;
	logic [2:0]    out_cons_q;
	logic [7:0]    out_byte_q;
	logic [5:0]    out_total_q;
	logic          out_last_q;

	store_wr_t     wr;
	entry_t        entry_rd;
	logic [7:0]    text_rd;

	logic in_xfer, cfg_wr, out_free, out_load;
	logic scan_issue, scan_done, hit, first_pass, last_byte, text_last;
	logic [1:0] ld_status;
	logic [2:0] ld_cons;
	logic [7:0] ld_byte;
	logic [5:0] ld_total;
	logic       ld_last;

	// ---------------------------------------------------------------
	// Configuration port: one register, decoded on the word address bit.
	// ---------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == 1'b0) ? {23'd0, entry_count_q} : 32'd0;

	// Counts above the store depth search the whole store.
	assign n_eff = (32'(entry_count_q) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : CW'(entry_count_q);

	// ---------------------------------------------------------------
	// Handshakes
	// ---------------------------------------------------------------
	assign in.ready  = (state_q == S_IDLE);
	assign in_xfer   = in.valid && in.ready;
	assign out_free  = !out_valid_q || out.ready;

	assign out.valid           = out_valid_q;
	assign out.status          = out_status_q;
	assign out.consumed_length = out_cons_q;
	assign out.text_byte       = out_byte_q;
	assign out.text_total      = out_total_q;
	assign out.last            = out_last_q;

	// Writes go straight to the store as they transfer.
	always_comb begin
		wr.code_we       = in_xfer && (in.command == CMD_CODE);
		wr.text_we       = in_xfer && (in.command == CMD_TEXT);
		wr.entry_index   = in.entry_index;
		wr.code_bytes    = in.code_bytes;
		wr.code_length   = in.code_length;
		wr.text_length   = in.text_length;
		wr.text_position = in.text_position;
		wr.text_value    = in.text_value;
	end

	// ---------------------------------------------------------------
	// Shared byte-compare unit and scan pipeline control
	// ---------------------------------------------------------------
	assign first_pass = (bidx_q == '0);
	assign scan_issue = (state_q == S_SCAN) && (rd_q != old_q);
	assign scan_done  = (state_q == S_SCAN) && (rd_q == old_q) && !v_s1 && !v_s2;
	// The first pass walks indices directly; later passes walk the survivors.
	assign e_s1 = first_pass ? idx_s1 : cand_rd_q;
	assign hit  = v_s2 && (32'(bidx_q) < 32'(entry_rd.code_length))
	              && (byte_at(win_q, 4'(bidx_q)) == byte_at(entry_rd.code, 4'(bidx_q)));
	assign last_byte = (32'(bidx_q) + 1) >= 32'(longest_q);
	assign text_last = (k_q + 6'd1) == hit_tlen_q;

	cptl_store #(
		.MAX_ENTRIES   (MAX_ENTRIES),
		.MAX_CODE_BYTES(MAX_CODE_BYTES),
		.MAX_TEXT_BYTES(MAX_TEXT_BYTES)
	) u_store (
		.clk        (clk),
		.wr         (wr),
		.entry_raddr(e_s1),
		.entry_rdata(entry_rd),
		.text_raddr ({hit_e_q, k_q[TW-1:0]}),
		.text_rdata (text_rd)
	);

	// Candidate list: read ahead at the scan pointer, compact at the hit count.
	always_ff @(posedge clk) begin
		if ((state_q == S_SCAN) && hit) begin
			cand_mem[mcnt_q[EW-1:0]] <= e_s2;
		end
		cand_rd_q <= cand_mem[rd_q[EW-1:0]];
	end

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	always_comb begin
		state_d   = state_q;
		out_load  = 1'b0;
		ld_status = ST_UNIQUE;
		ld_cons   = hit_clen_q;
		ld_byte   = text_rd;
		ld_total  = hit_tlen_q;
		ld_last   = text_last;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer && (in.command == CMD_LOOKUP)) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_done) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				priority if (mcnt_q == CW'(1)) begin
					state_d = (hit_tlen_q == 6'd0) ? S_STATUS : S_TXT_RD;
				end else if ((mcnt_q == '0) || last_byte) begin
					state_d = S_STATUS;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_TXT_RD: begin
				state_d = S_TXT_OUT;
			end
			S_TXT_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = text_last ? S_IDLE : S_TXT_RD;
				end
			end
			S_STATUS: begin
				ld_status = pend_status_q;
				ld_cons   = (pend_status_q == ST_UNIQUE) ? hit_clen_q : 3'd0;
				ld_byte   = 8'd0;
				ld_total  = 6'd0;
				ld_last   = 1'b1;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			entry_count_q <= 9'd0;
			out_valid_q   <= 1'b0;
			rd_q          <= '0;
			old_q         <= '0;
			mcnt_q        <= '0;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			bidx_q        <= '0;
			longest_q     <= 3'd0;
			k_q           <= 6'd0;
		end else begin
			state_q <= state_d;
			if (cfg_wr && (paddr[2] == 1'b0)) begin
				entry_count_q <= pwdata[8:0];
			end

			// Hold the result until it transfers.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out.ready) begin
				out_valid_q <= 1'b0;
			end

			v_s1 <= scan_issue;
			v_s2 <= v_s1 && (state_q == S_SCAN);

			if (scan_issue) begin
				rd_q <= rd_q + CW'(1);
			end
			if ((state_q == S_SCAN) && hit) begin
				mcnt_q <= mcnt_q + CW'(1);
			end
			// Longest code among searched entries, taken on the first pass.
			if ((state_q == S_SCAN) && v_s2 && first_pass
			    && (entry_rd.code_length > longest_q)) begin
				longest_q <= entry_rd.code_length;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_xfer && (in.command == CMD_LOOKUP)) begin
						bidx_q    <= '0;
						longest_q <= 3'd0;
						old_q     <= n_eff;
						rd_q      <= '0;
						mcnt_q    <= '0;
					end
				end
				S_DECIDE: begin
					k_q <= 6'd0;
					// Advance to the next code byte with the survivors.
					if ((mcnt_q != CW'(1)) && (mcnt_q != '0) && !last_byte) begin
						bidx_q <= bidx_q + BW'(1);
						old_q  <= mcnt_q;
						rd_q   <= '0;
						mcnt_q <= '0;
					end
				end
				S_TXT_OUT: begin
					if (out_free) begin
						k_q <= k_q + 6'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_xfer && (in.command == CMD_LOOKUP)) begin
			win_q <= in.code_bytes;
		end
		idx_s1 <= rd_q[EW-1:0];
		e_s2   <= e_s1;
		if ((state_q == S_SCAN) && hit) begin
			hit_e_q    <= e_s2;
			hit_clen_q <= entry_rd.code_length;
			hit_tlen_q <= entry_rd.text_length;
		end
		if (state_q == S_DECIDE) begin
			priority if (mcnt_q == CW'(1)) begin
				pend_status_q <= ST_UNIQUE;
			end else if (mcnt_q == '0) begin
				pend_status_q <= ST_NONE;
			end else begin
				pend_status_q <= ST_AMBIG;
			end
		end
		if (out_load) begin
			out_status_q <= ld_status;
			out_cons_q   <= ld_cons;
			out_byte_q   <= ld_byte;
			out_total_q  <= ld_total;
			out_last_q   <= ld_last;
		end
	end

endmodule

// ===== rtl/core/cptl_checker.sv =====
`include "code_prefix_to_text_lookup_top_assert.svh"

module cptl_checker
	import cptl_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] in_command,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] status,
	input logic [2:0] consumed_length,
	input logic [7:0] text_byte,
	input logic [5:0] text_total,
	input logic       last
);

	// A stalled result holds its contents.
	`CPTL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(consumed_length) && $stable(text_byte) && $stable(text_total) && $stable(last), "stalled result changed")

	// Only a unique match with text streams more than one result.
	`CPTL_ASSERT(a_mid_unique, out_valid && !last |-> status == ST_UNIQUE && text_total != 6'd0, "non-final result is not text")

	// A failed lookup reports a single empty result.
	`CPTL_ASSERT(a_fail_empty, out_valid && status != ST_UNIQUE |-> consumed_length == 3'd0 && text_byte == 8'd0 && text_total == 6'd0 && last, "failed lookup result not empty")

	// A lookup that transfers keeps the input side closed while it runs.
	`CPTL_ASSERT_NEXT(a_lookup_busy, in_valid && in_ready && in_command == CMD_LOOKUP, !in_ready, "input ready during lookup")

endmodule

bind code_prefix_to_text_lookup_top cptl_checker u_cptl_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in.valid),
	.in_ready       (in.ready),
	.in_command     (in.command),
	.out_valid      (out.valid),
	.out_ready      (out.ready),
	.status         (out.status),
	.consumed_length(out.consumed_length),
	.text_byte      (out.text_byte),
	.text_total     (out.text_total),
	.last           (out.last)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import cptl_pkg::*;

	// Sizes of the dictionary as built with default parameters
	localparam int ENTRIES    = 256;
	localparam int CODE_BYTES = 4;
	localparam int TEXT_BYTES = 32;

	// Command code that the block must ignore
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	// Register map: entry_count is register 0
	localparam logic [2:0] ADDR_ENTRY_COUNT = 3'd0;

	// Cycles to let a trailing write settle before touching the register
	localparam int SETTLE_CYCLES = 20;
	// Quiet cycles after the last expected result, to catch stray results
	localparam int DRAIN_CYCLES = 200;
	// Hard stop: far beyond the slowest correct run
	localparam longint TIMEOUT_NS = 60_000_000;
	// Cap on printed mismatch lines
	localparam int PRINT_LIMIT = 40;

	typedef struct {
		logic [1:0]  command;
		logic [7:0]  entry_index;
		logic [31:0] code_bytes;
		logic [2:0]  code_length;
		logic [5:0]  text_length;
		logic [4:0]  text_position;
		logic [7:0]  text_value;
	} dict_item_t;

	typedef struct {
		status_t    status;
		logic [2:0] consumed_length;
		logic [7:0] text_byte;
		logic [5:0] text_total;
		logic       last;
	} lookup_result_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	cptl_in_if  dict_in ();
	cptl_out_if dict_out ();

	code_prefix_to_text_lookup_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.in      (dict_in),
		.out     (dict_out),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow copy of the dictionary, as the block should hold it
	logic [31:0] dict_code     [ENTRIES];
	logic [2:0]  dict_code_len [ENTRIES];
	logic [5:0]  dict_text_len [ENTRIES];
	logic [7:0]  dict_text     [ENTRIES][TEXT_BYTES];
	// Which text bytes have been written; lookups only reach written ones
	bit          text_loaded   [ENTRIES][TEXT_BYTES];
	int unsigned entry_count_reg = 0;

	// Results still owed by the block, oldest first
	lookup_result_t pending_results[$];
	int unsigned    error_count = 0;

	// Random idling on both sides; a long receiver hold-off on request
	bit          idling = 1'b0;
	int unsigned result_hold_req = 0;
	int unsigned hold_left = 0;
	int unsigned ready_gap_left = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Hard stop if the run never drains
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("Verification failed");
		$finish;
	end

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		error_count++;
		if (error_count <= PRINT_LIMIT) begin
			$display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		end
	endtask

	// Narrow the searched entries byte by byte against the window and queue what the
	// lookup must return: the text of a single survivor, or one status result.
	function automatic void predict_lookup(input logic [31:0] window);
		int unsigned    searched;
		int unsigned    longest;
		int unsigned    nbytes;
		int unsigned    total;
		int unsigned    e;
		int             survivors[$];
		int             kept[$];
		lookup_result_t res;
		searched = (entry_count_reg > ENTRIES) ? ENTRIES : entry_count_reg;
		longest = 0;
		for (int i = 0; i < searched; i++) begin
			survivors.push_back(i);
			if (dict_code_len[i] > longest) begin
				longest = dict_code_len[i];
			end
		end
		res.consumed_length = 3'd0;
		res.text_byte = 8'd0;
		res.text_total = 6'd0;
		res.last = 1'b1;
		nbytes = 1;
		while (1) begin
			kept.delete();
			foreach (survivors[j]) begin
				if (nbytes <= dict_code_len[survivors[j]] &&
						window[8*(nbytes-1) +: 8] == dict_code[survivors[j]][8*(nbytes-1) +: 8]) begin
					kept.push_back(survivors[j]);
				end
			end
			survivors = kept;
			if (survivors.size() == 1) begin
				e = survivors[0];
				total = dict_text_len[e];
				res.status = ST_UNIQUE;
				res.consumed_length = dict_code_len[e];
				res.text_total = 6'(total);
				if (total == 0) begin
					// empty text still gives one closing result
					pending_results.push_back(res);
				end else begin
					for (int k = 0; k < total; k++) begin
						res.text_byte = dict_text[e][k];
						res.last = (k == total - 1);
						pending_results.push_back(res);
					end
				end
				return;
			end
			if (survivors.size() == 0) begin
				res.status = ST_NONE;
				pending_results.push_back(res);
				return;
			end
			if (nbytes >= longest) begin
				// several left after the longest code: give up as ambiguous
				res.status = ST_AMBIG;
				pending_results.push_back(res);
				return;
			end
			nbytes++;
		end
	endfunction

	// Offer one item, hold it until the transfer, then update the shadow state.
	// Valid stays high on return so back-to-back items need no second assignment.
	task automatic apply_item(input dict_item_t it);
		int unsigned gap;
		int unsigned r;
		gap = 0;
		if (idling) begin
			r = $urandom_range(0, 99);
			if (r >= 90) begin
				gap = $urandom_range(12, 60);
			end else if (r >= 55) begin
				gap = $urandom_range(1, 3);
			end
		end
		if (gap > 0) begin
			dict_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		dict_in.valid         <= 1'b1;
		dict_in.command       <= it.command;
		dict_in.entry_index   <= it.entry_index;
		dict_in.code_bytes    <= it.code_bytes;
		dict_in.code_length   <= it.code_length;
		dict_in.text_length   <= it.text_length;
		dict_in.text_position <= it.text_position;
		dict_in.text_value    <= it.text_value;
		@(posedge clk);
		while (!dict_in.ready) @(posedge clk);
		case (it.command)
			CMD_CODE: begin
				dict_code[it.entry_index]     = it.code_bytes;
				dict_code_len[it.entry_index] = (it.code_length > CODE_BYTES) ? 3'(CODE_BYTES)
					: it.code_length;
				dict_text_len[it.entry_index] = (it.text_length > TEXT_BYTES) ? 6'(TEXT_BYTES)
					: it.text_length;
			end
			CMD_TEXT: begin
				dict_text[it.entry_index][it.text_position]   = it.text_value;
				text_loaded[it.entry_index][it.text_position] = 1'b1;
			end
			CMD_LOOKUP: begin
				predict_lookup(it.code_bytes);
			end
			default: begin
			end
		endcase
	endtask

	task automatic write_text(input int unsigned idx, input int unsigned pos,
			input logic [7:0] value);
		dict_item_t it;
		it.command       = CMD_TEXT;
		it.entry_index   = 8'(idx);
		it.code_bytes    = $urandom;
		it.code_length   = 3'($urandom_range(0, 7));
		it.text_length   = 6'($urandom_range(0, 63));
		it.text_position = 5'(pos);
		it.text_value    = value;
		apply_item(it);
	endtask

	// Write an entry's code, then fill every text byte it can expose that is not yet
	// written, so no lookup ever reads an unwritten byte.
	task automatic load_entry(input int unsigned idx, input logic [31:0] code,
			input int unsigned clen, input int unsigned tlen);
		dict_item_t  it;
		int unsigned stored_len;
		it.command       = CMD_CODE;
		it.entry_index   = 8'(idx);
		it.code_bytes    = code;
		it.code_length   = 3'(clen);
		it.text_length   = 6'(tlen);
		it.text_position = 5'($urandom_range(0, 31));
		it.text_value    = 8'($urandom_range(0, 255));
		apply_item(it);
		stored_len = dict_text_len[idx];
		for (int k = 0; k < stored_len; k++) begin
			if (!text_loaded[idx][k] || $urandom_range(0, 3) == 0) begin
				write_text(idx, k, 8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic lookup(input logic [31:0] window);
		dict_item_t it;
		it.command       = CMD_LOOKUP;
		it.entry_index   = 8'($urandom_range(0, 255));
		it.code_bytes    = window;
		it.code_length   = 3'($urandom_range(0, 7));
		it.text_length   = 6'($urandom_range(0, 63));
		it.text_position = 5'($urandom_range(0, 31));
		it.text_value    = 8'($urandom_range(0, 255));
		apply_item(it);
	endtask

	task automatic send_noise();
		dict_item_t it;
		it.command       = CMD_UNUSED;
		it.entry_index   = 8'($urandom_range(0, 255));
		it.code_bytes    = $urandom;
		it.code_length   = 3'($urandom_range(0, 7));
		it.text_length   = 6'($urandom_range(0, 63));
		it.text_position = 5'($urandom_range(0, 31));
		it.text_value    = 8'($urandom_range(0, 255));
		apply_item(it);
	endtask

	// Drain the block, then write entry_count and read it back over the APB port
	task automatic set_entry_count(input int unsigned value);
		dict_in.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_ENTRY_COUNT;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// write lands at this edge; go straight into a read setup
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[8:0] !== value[8:0]) begin
			report_mismatch("entry_count read back", prdata[8:0], value[8:0]);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		entry_count_reg = value;
	endtask

	// Code words with a few favored byte values, so prefixes collide often
	function automatic logic [31:0] rand_code();
		logic [31:0] c;
		for (int b = 0; b < CODE_BYTES; b++) begin
			case ($urandom_range(0, 5))
				0: c[8*b +: 8] = 8'h00;
				1: c[8*b +: 8] = 8'hFF;
				2: c[8*b +: 8] = 8'h5A;
				default: c[8*b +: 8] = 8'($urandom_range(0, 255));
			endcase
		end
		return c;
	endfunction

	// Window that starts with entry e's code and carries random bytes after it
	function automatic logic [31:0] window_for(input int unsigned e);
		logic [31:0] w;
		w = $urandom;
		for (int b = 0; b < CODE_BYTES; b++) begin
			if (b < dict_code_len[e]) begin
				w[8*b +: 8] = dict_code[e][8*b +: 8];
			end
		end
		return w;
	endfunction

	// Receiver: random ready gaps, plus one long hold-off counted here on request
	always @(posedge clk) begin : drive_result_ready
		if (result_hold_req != 0) begin
			hold_left       <= result_hold_req;
			result_hold_req <= 0;
			dict_out.ready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left      <= hold_left - 1;
			dict_out.ready <= 1'b0;
		end else if (ready_gap_left != 0) begin
			ready_gap_left <= ready_gap_left - 1;
			dict_out.ready <= 1'b0;
		end else if (idling && $urandom_range(0, 99) < 25) begin
			ready_gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 70)
				: $urandom_range(0, 2);
			dict_out.ready <= 1'b0;
		end else begin
			dict_out.ready <= 1'b1;
		end
	end

	// Compare every result transfer with the oldest expectation
	always @(posedge clk) begin : check_results
		lookup_result_t want;
		if (arst_n && dict_out.valid && dict_out.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, status", dict_out.status, 0);
			end else begin
				want = pending_results.pop_front();
				if (dict_out.status !== want.status) begin
					report_mismatch("status", dict_out.status, want.status);
				end
				if (dict_out.consumed_length !== want.consumed_length) begin
					report_mismatch("consumed_length", dict_out.consumed_length,
						want.consumed_length);
				end
				if (dict_out.text_byte !== want.text_byte) begin
					report_mismatch("text_byte", dict_out.text_byte, want.text_byte);
				end
				if (dict_out.text_total !== want.text_total) begin
					report_mismatch("text_total", dict_out.text_total, want.text_total);
				end
				if (dict_out.last !== want.last) begin
					report_mismatch("last", dict_out.last, want.last);
				end
			end
		end
	end

	// Nothing searched: every lookup misses
	task automatic test_empty_dictionary();
		set_entry_count(0);
		idling <= 1'b1;
		lookup(32'h0000_0000);
		lookup(32'hFFFF_FFFF);
	endtask

	// Hand-built entries covering each corner of the search
	task automatic test_directed_entries();
		load_entry(0, 32'h0000_0041, 1, 3);
		// empty text
		load_entry(1, 32'h0000_4342, 2, 0);
		// both lengths past their limits, so both saturate
		load_entry(2, 32'hFFFF_FFFF, 7, 63);
		load_entry(3, 32'h0000_0000, 4, 1);
		// zero-length code: never matches, even though byte 0 equals entry 0's
		load_entry(4, 32'h0000_0041, 0, 2);
		// two entries with the same full-length code
		load_entry(5, 32'h3322_5544, 4, 0);
		load_entry(6, 32'h3322_5544, 4, 2);
		// shares byte 0 with entries 5 and 6, splits off at byte 1
		load_entry(7, 32'h0077_0044, 3, 4);
		set_entry_count(8);
		// one-byte prefix match with junk after it
		lookup(32'hDEAD_BE41);
		lookup(32'h0000_4342);
		lookup(32'hFFFF_FFFF);
		lookup(32'h0000_0000);
		// identical codes survive to the longest length: ambiguous
		lookup(32'h3322_5544);
		// the duplicate pair mismatches at byte 2, before the longest length: no match
		lookup(32'h0000_5544);
		lookup(32'h0077_0044);
		lookup(32'h1234_5678);
		send_noise();
		// limit the search below the duplicate pair, then below entry 2
		set_entry_count(5);
		lookup(32'h3322_5544);
		set_entry_count(2);
		lookup(32'hFFFF_FFFF);
	endtask

	// Fill the whole table and search all of it, including counts past the size
	task automatic test_full_table();
		int unsigned clen;
		int unsigned tlen;
		int unsigned r;
		for (int idx = 8; idx < ENTRIES; idx++) begin
			r = $urandom_range(0, 99);
			clen = (r < 5) ? 0 : ((r < 12) ? $urandom_range(5, 7) : $urandom_range(1, 4));
			tlen = ($urandom_range(0, 99) < 95) ? 0 : $urandom_range(1, 3);
			load_entry(idx, rand_code(), clen, tlen);
		end
		set_entry_count(256);
		lookup(window_for($urandom_range(0, ENTRIES - 1)));
		lookup(window_for($urandom_range(0, ENTRIES - 1)));
		lookup(window_for(ENTRIES - 1));
		lookup($urandom);
		set_entry_count(511);
		lookup(window_for($urandom_range(0, ENTRIES - 1)));
		lookup($urandom);
		set_entry_count(257);
		lookup(window_for(ENTRIES - 1));
	endtask

	// Phases of mixed traffic: lookups aimed at a searched entry, plus rewrites,
	// loose text writes, near misses and ignored commands
	task automatic test_random_traffic();
		int unsigned n;
		int unsigned span;
		int unsigned r;
		int unsigned idx;
		int unsigned clen;
		int unsigned tlen;
		logic [31:0] w;
		for (int phase = 0; phase < 2; phase++) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				n = $urandom_range(1, 24);
			end else if (r < 85) begin
				n = $urandom_range(25, 80);
			end else if (r < 92) begin
				n = 0;
			end else begin
				n = ($urandom_range(0, 1) == 1) ? 256 : $urandom_range(257, 511);
			end
			set_entry_count(n);
			span = (n == 0) ? 1 : ((n > ENTRIES) ? ENTRIES : n);
			for (int k = 0; k < 12; k++) begin
				r = $urandom_range(0, 99);
				if (r < 40 && n != 0) begin
					lookup(window_for($urandom_range(0, span - 1)));
				end else if (r < 55) begin
					// near miss: flip one bit of a good window, or go fully random
					w = window_for($urandom_range(0, span - 1));
					if ($urandom_range(0, 1) == 1) begin
						w = w ^ (32'h1 << $urandom_range(0, 31));
					end else begin
						w = $urandom;
					end
					lookup(w);
				end else if (r < 72) begin
					idx = ($urandom_range(0, 3) != 0) ? $urandom_range(0, span - 1)
						: $urandom_range(0, ENTRIES - 1);
					r = $urandom_range(0, 99);
					clen = (r < 8) ? 0 : ((r < 16) ? $urandom_range(5, 7) : $urandom_range(1, 4));
					r = $urandom_range(0, 99);
					if (r < 10) begin
						tlen = $urandom_range(33, 63);
					end else if (r < 20) begin
						tlen = TEXT_BYTES;
					end else if (r < 55) begin
						tlen = 0;
					end else begin
						tlen = $urandom_range(1, 6);
					end
					load_entry(idx, rand_code(), clen, tlen);
				end else if (r < 88) begin
					write_text($urandom_range(0, ENTRIES - 1), $urandom_range(0, TEXT_BYTES - 1),
						8'($urandom_range(0, 255)));
				end else begin
					send_noise();
				end
			end
		end
	endtask

	// Hold the receiver off for a long stretch while lookups keep coming, so the
	// output fills and the input stalls
	task automatic test_output_backpressure();
		load_entry(9, 32'hC3A5_0F96, 4, TEXT_BYTES);
		set_entry_count(12);
		idling <= 1'b0;
		@(posedge clk);
		result_hold_req <= 400;
		for (int k = 0; k < 8; k++) begin
			lookup(32'hC3A5_0F96);
		end
		idling <= 1'b1;
		for (int k = 0; k < 6; k++) begin
			lookup(window_for($urandom_range(0, 11)));
		end
	endtask

	initial begin : run_tests
		// Drive every input to a known value before reset lifts
		arst_n                = 1'b0;
		psel                  = 1'b0;
		penable               = 1'b0;
		pwrite                = 1'b0;
		paddr                 = '0;
		pwdata                = '0;
		dict_in.valid         = 1'b0;
		dict_in.command       = '0;
		dict_in.entry_index   = '0;
		dict_in.code_bytes    = '0;
		dict_in.code_length   = '0;
		dict_in.text_length   = '0;
		dict_in.text_position = '0;
		dict_in.text_value    = '0;
		dict_out.ready        = 1'b0;
		repeat (4) @(posedge clk);
		// Release reset away from the active edge
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		test_empty_dictionary();
		test_directed_entries();
		test_full_table();
		test_random_traffic();
		test_output_backpressure();

		// Drop valid, wait for the last owed result, then watch for strays
		dict_in.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/cptl_pkg.sv
rtl/core/cptl_if.sv
rtl/core/cptl_store.sv
rtl/core/code_prefix_to_text_lookup_top.sv
rtl/core/cptl_checker.sv
tb/sv/tb_top.sv
